// ----- hw/rtl/skf_pkg.sv -----
package skf_pkg;

    // Fixed field widths of the block.
    localparam int MEAS_W = 32;
    localparam int EST_W  = 48;
    localparam int VAR_W  = 32;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 4;

    // Register map, one 32-bit word per register.
    typedef enum logic [1:0] {
        REG_INITIAL_ESTIMATE  = 2'd0,
        REG_INITIAL_VARIANCE  = 2'd1,
        REG_PROCESS_NOISE     = 2'd2,
        REG_MEASUREMENT_NOISE = 2'd3
    } cfg_reg_t;

    // Register reset values.
    localparam logic [DATA_W-1:0] INITIAL_ESTIMATE_RST  = 32'd0;
    localparam logic [DATA_W-1:0] INITIAL_VARIANCE_RST  = 32'd65536;
    localparam logic [DATA_W-1:0] PROCESS_NOISE_RST     = 32'd66;
    localparam logic [DATA_W-1:0] MEASUREMENT_NOISE_RST = 32'd65536;

endpackage

// ----- hw/rtl/skf_if.sv -----
// Measurement channel: one measurement and its restart flag per item.
interface skf_meas_if;
    logic                                valid;
    logic                                ready;
    logic signed [skf_pkg::MEAS_W-1:0]   measurement;
    logic                                restart;

    modport source (output valid, output measurement, output restart, input ready);
    modport sink   (input valid, input measurement, input restart, output ready);
endinterface

// Result channel: updated estimate and variance per item.
interface skf_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [skf_pkg::EST_W-1:0]    estimate;
    logic        [skf_pkg::VAR_W-1:0]    variance;

    modport source (output valid, output estimate, output variance, input ready);
    modport sink   (input valid, input estimate, input variance, output ready);
endinterface

// ----- hw/rtl/skf_gain_div.sv -----
// Restoring divider, one quotient bit per cycle, MSB first.
// Computes floor(num * 2^F / den) for num <= den; a zero divisor gives zero.
// The divisor must stay stable while the division runs.
module skf_gain_div #(
    parameter int F = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [31:0]  num,
    input  logic [32:0]  den,
    output logic [F:0]   gain,
    output logic         done
);

    localparam int CW = $clog2(F + 1);

    logic [33:0]   rem_reg;
    logic [F:0]    quo_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic          zero_reg;

    logic [34:0]   trial;
    logic          ge;
    logic [33:0]   rem_kept;
    logic [33:0]   rem_next;

    // Trial subtraction; the remainder stays below the divisor once reduced.
    always_comb
    begin
        trial    = {1'b0, rem_reg} - {2'b00, den};
        ge       = ~trial[34];
        rem_kept = ge ? trial[33:0] : rem_reg;
        rem_next = {rem_kept[32:0], 1'b0};
    end

    // Control state resets; the remainder is loaded on start and the quotient bits shift in.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            quo_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            zero_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            rem_reg  <= {2'b00, num};
            zero_reg <= (den == 33'd0);
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[F-1:0], ge};
            rem_reg <= rem_next;
            if (cnt_reg == CW'(F))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign gain = zero_reg ? '0 : quo_reg;
    assign done = done_reg;

endmodule

// ----- hw/rtl/skf_serial_mul.sv -----
// Shift-add multiplier, one multiplier bit per cycle, LSB first.
// Computes floor(a * b / 2^F) for b <= 2^F, so the product never exceeds a.
// Operand a must stay stable while the multiplication runs.
module skf_serial_mul #(
    parameter int F  = 16,
    parameter int AW = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [AW-1:0] a,
    input  logic [F:0]    b,
    output logic [AW-1:0] prod,
    output logic          done
);

    localparam int CW = $clog2(F + 1);

    logic [AW-1:0] acc_reg;
    logic [F:0]    b_sr_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [AW:0]   sum;

    // Add the partial product for the current multiplier bit.
    assign sum = {1'b0, acc_reg} + (b_sr_reg[0] ? {1'b0, a} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            b_sr_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            acc_reg  <= '0;
            b_sr_reg <= b;
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            b_sr_reg <= {1'b0, b_sr_reg[F:1]};
            if (cnt_reg == CW'(F))
            begin
                // Top bit has weight 2^F, which cancels the final scaling.
                acc_reg  <= sum[AW-1:0];
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                // Drop one fraction bit per lower multiplier bit.
                acc_reg <= sum[AW:1];
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign prod = acc_reg;
    assign done = done_reg;

endmodule

// ----- hw/rtl/scalar_kalman_filter_unit.sv -----
// One-dimensional Kalman filter with a constant-state model. Each item on the
// meas channel carries a signed integer measurement and a restart flag; the
// block answers with one item on the result channel holding the new estimate
// (signed, FRACTION_BITS fraction bits, 48 bits) and its variance (unsigned,
// 32 bits, saturated). Restart reloads the estimate and variance from the
// initial_estimate and initial_variance registers before the update; writes to
// those two registers otherwise reach the filter state only through restart.
// An accepted item passes through these steps in order: the predicted variance
// and innovation are formed and registered, the bit-serial divider produces the
// gain one quotient bit per cycle, the two bit-serial multipliers run side by
// side for the estimate correction and the new variance, and the output
// register is loaded. One item is in flight at a time, so a new item is
// accepted only once the previous one has left the sequencer; a new item is
// accepted while the previous result still waits in the output register, and
// a result that still waits there when the next one is ready holds the block
// until the receiver takes it.
module scalar_kalman_filter_unit #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [skf_pkg::ADDR_W-1:0]   paddr,
    input  logic [skf_pkg::DATA_W-1:0]   pwdata,
    output logic [skf_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,

    skf_meas_if.sink                     meas,
    skf_result_if.source                 result
);

    localparam int F   = FRACTION_BITS;
    localparam int EW  = skf_pkg::EST_W;
    localparam int MSW = skf_pkg::MEAS_W;
    localparam int ZW  = MSW + F;
    localparam int DW  = ((ZW > EW) ? ZW : EW) + 1;
    localparam int XW  = DW + 1;

    localparam logic [XW-1:0] EST_MAX_X = {{(XW - EW + 1){1'b0}}, {(EW - 1){1'b1}}};
    localparam logic [XW-1:0] EST_MIN_X = {{(XW - EW + 1){1'b1}}, {(EW - 1){1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_MUL,
        S_DONE
    } state_t;

    // Saturate a wide signed value to the 48-bit estimate range.
    function automatic logic [EW-1:0] sat_est(input logic [XW-1:0] v);
        logic [EW-1:0] r;
        if ($signed(v) > $signed(EST_MAX_X))
        begin
            r = EST_MAX_X[EW-1:0];
        end
        else if ($signed(v) < $signed(EST_MIN_X))
        begin
            r = EST_MIN_X[EW-1:0];
        end
        else
        begin
            r = v[EW-1:0];
        end
        return r;
    endfunction

    // Configuration registers.
    logic [skf_pkg::DATA_W-1:0] init_est_reg;
    logic [skf_pkg::DATA_W-1:0] init_var_reg;
    logic [skf_pkg::DATA_W-1:0] proc_noise_reg;
    logic [skf_pkg::DATA_W-1:0] meas_noise_reg;

    // Filter state and per-item working registers.
    state_t                     state_reg;
    logic [EW-1:0]              estimate_reg;
    logic [31:0]                variance_reg;
    logic [MSW-1:0]             meas_reg;
    logic [31:0]                p_reg;
    logic [32:0]                denom_reg;
    logic [DW-1:0]              mag_reg;
    logic                       neg_reg;
    logic                       div_start_reg;
    logic                       mul_start_reg;
    logic                       res_valid_reg;
    logic [EW-1:0]              res_est_reg;
    logic [31:0]                res_var_reg;

    logic                       cfg_write;
    logic [EW-1:0]              load_est;
    logic [32:0]                p_sum;
    logic [31:0]                p_next;
    logic [32:0]                denom_next;
    logic [DW-1:0]              d_next;
    logic [DW-1:0]              mag_next;
    logic [F:0]                 gain;
    logic [F:0]                 one_minus_gain;
    logic                       div_done;
    logic [DW-1:0]              corr;
    logic [31:0]                var_prod;
    logic                       corr_done;
    logic                       var_done;
    logic [XW-1:0]              est_wide;
    logic [XW-1:0]              estimate_next;
    logic                       res_load;

    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    // Register read-back.
    always_comb
    begin
        case (skf_pkg::cfg_reg_t'(paddr[3:2]))
            skf_pkg::REG_INITIAL_ESTIMATE:  prdata = init_est_reg;
            skf_pkg::REG_INITIAL_VARIANCE:  prdata = init_var_reg;
            skf_pkg::REG_PROCESS_NOISE:     prdata = proc_noise_reg;
            skf_pkg::REG_MEASUREMENT_NOISE: prdata = meas_noise_reg;
            default:                        prdata = '0;
        endcase
    end

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_est_reg   <= skf_pkg::INITIAL_ESTIMATE_RST;
            init_var_reg   <= skf_pkg::INITIAL_VARIANCE_RST;
            proc_noise_reg <= skf_pkg::PROCESS_NOISE_RST;
            meas_noise_reg <= skf_pkg::MEASUREMENT_NOISE_RST;
        end
        else if (cfg_write)
        begin
            case (skf_pkg::cfg_reg_t'(paddr[3:2]))
                skf_pkg::REG_INITIAL_ESTIMATE:  init_est_reg   <= pwdata;
                skf_pkg::REG_INITIAL_VARIANCE:  init_var_reg   <= pwdata;
                skf_pkg::REG_PROCESS_NOISE:     proc_noise_reg <= pwdata;
                skf_pkg::REG_MEASUREMENT_NOISE: meas_noise_reg <= pwdata;
                default:                        ;
            endcase
        end
    end

    // Restart value: the integer estimate scaled to fixed point.
    assign load_est = sat_est({{(XW - ZW){init_est_reg[MSW-1]}}, init_est_reg, {F{1'b0}}});

    // Predicted variance, gain denominator and innovation magnitude.
    always_comb
    begin
        p_sum      = {1'b0, variance_reg} + {1'b0, proc_noise_reg};
        p_next     = p_sum[32] ? '1 : p_sum[31:0];
        denom_next = {1'b0, p_next} + {1'b0, meas_noise_reg};
        d_next     = {{(DW - ZW){meas_reg[MSW-1]}}, meas_reg, {F{1'b0}}}
                   - {{(DW - EW){estimate_reg[EW-1]}}, estimate_reg};
        mag_next   = d_next[DW-1] ? (~d_next + 1'b1) : d_next;
    end

    assign one_minus_gain = {1'b1, {F{1'b0}}} - gain;

    // Corrected estimate, before it is saturated to 48 bits.
    always_comb
    begin
        est_wide      = {{(XW - EW){estimate_reg[EW-1]}}, estimate_reg};
        estimate_next = neg_reg ? (est_wide - {1'b0, corr}) : (est_wide + {1'b0, corr});
    end

    // The finished item moves into the output register once it is free.
    assign res_load = (state_reg == S_DONE) && (!res_valid_reg || result.ready);

    skf_gain_div #(
        .F (F)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (p_reg),
        .den   (denom_reg),
        .gain  (gain),
        .done  (div_done)
    );

    skf_serial_mul #(
        .F  (F),
        .AW (DW)
    ) u_corr_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start_reg),
        .a     (mag_reg),
        .b     (gain),
        .prod  (corr),
        .done  (corr_done)
    );

    skf_serial_mul #(
        .F  (F),
        .AW (32)
    ) u_var_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start_reg),
        .a     (p_reg),
        .b     (one_minus_gain),
        .prod  (var_prod),
        .done  (var_done)
    );

    assign meas.ready      = (state_reg == S_IDLE);
    assign result.valid    = res_valid_reg;
    assign result.estimate = res_est_reg;
    assign result.variance = res_var_reg;

    // Sequencer, filter state and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            estimate_reg  <= '0;
            variance_reg  <= skf_pkg::INITIAL_VARIANCE_RST;
            meas_reg      <= '0;
            p_reg         <= '0;
            denom_reg     <= '0;
            mag_reg       <= '0;
            neg_reg       <= 1'b0;
            div_start_reg <= 1'b0;
            mul_start_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            res_est_reg   <= '0;
            res_var_reg   <= '0;
        end
        else
        begin
            div_start_reg <= (state_reg == S_PREP);
            mul_start_reg <= (state_reg == S_DIV) && div_done;

            // The output register holds a result until the receiver takes it.
            if (res_load)
            begin
                res_est_reg   <= sat_est(estimate_next);
                res_var_reg   <= var_prod;
                res_valid_reg <= 1'b1;
            end
            else if (res_valid_reg && result.ready)
            begin
                res_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (meas.valid)
                    begin
                        meas_reg <= meas.measurement;
                        if (meas.restart)
                        begin
                            estimate_reg <= load_est;
                            variance_reg <= init_var_reg;
                        end
                        state_reg <= S_PREP;
                    end
                end
                S_PREP:
                begin
                    p_reg     <= p_next;
                    denom_reg <= denom_next;
                    mag_reg   <= mag_next;
                    neg_reg   <= d_next[DW-1];
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    if (corr_done && var_done)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    // Wait for the output register to free up.
                    if (res_load)
                    begin
                        estimate_reg <= sat_est(estimate_next);
                        variance_reg <= var_prod;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
